/* hw/rtl/obst_pkg.sv */
// shared types and constants for the optimal binary search tree table builder
`timescale 1ns / 1ps
`default_nettype none

package obst_pkg;

	// default and field widths
	localparam int MAX_KEYS_DEF = 8;
	localparam int IDX_W        = 4;
	localparam int WIN_W        = 8;
	localparam int WEIGHT_W     = 13;
	localparam int COST_W       = 16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic             diag_wr;   // write empty span (i, i)
		logic             wsum;      // read w[i][j-1] and form p[j] + q[j]
		logic             scan;      // read candidate costs for root k
		logic             first;     // first candidate of a span
		logic             span_wr;   // write span (i, j) results
		logic             out_rd;    // read span (i, j) for output
		logic             out_load;  // load output register
		logic             out_last;  // loaded entry is the last of the run
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
	} obst_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic             start;     // request accepted that closes the weight load
		logic             out_free;  // output register can take an entry this cycle
		logic [IDX_W-1:0] n;         // effective key count
	} obst_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/obst_dpath.sv */
// datapath: weight stores, span tables, candidate compare and output register
`timescale 1ns / 1ps
`default_nettype none

module obst_dpath
	import obst_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [IDX_W-1:0]    cfg_wr_data,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [IDX_W-1:0]    weight_index,
	input  wire logic [WIN_W-1:0]    success_weight,
	input  wire logic [WIN_W-1:0]    failure_weight,
	input  wire obst_cmd_t           cmd,
	output obst_sts_t                sts,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [IDX_W-1:0]         span_start,
	output logic [IDX_W-1:0]         span_end,
	output logic [WEIGHT_W-1:0]      span_weight,
	output logic [COST_W-1:0]        span_cost,
	output logic [IDX_W-1:0]         span_root,
	output logic                     final_entry
);

	localparam int SIDE   = MAX_KEYS + 1;
	localparam int KEY_W  = $clog2(SIDE);
	localparam int DEPTH  = SIDE * SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CAND_W = COST_W + 1;

	// row-major span address
	function automatic logic [ADDR_W-1:0] span_addr(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		return ADDR_W'(ADDR_W'(a) * ADDR_W'(SIDE) + ADDR_W'(b));
	endfunction

	logic [IDX_W-1:0]    key_count_q;
	logic [WIN_W-1:0]    succ_q [SIDE];
	logic [WIN_W-1:0]    fail_q [SIDE];
	logic [WEIGHT_W-1:0] wmem [DEPTH];
	logic [COST_W-1:0]   cmem [DEPTH];
	logic [IDX_W-1:0]    rmem [DEPTH];

	logic [WEIGHT_W-1:0] wt_rd_q;
	logic [COST_W-1:0]   ca_q;
	logic [COST_W-1:0]   cb_q;
	logic [IDX_W-1:0]    rt_rd_q;
	logic [WEIGHT_W-1:0] pq_s1;
	logic                wsum_s1;
	logic                scan_s1;
	logic                first_s1;
	logic [IDX_W-1:0]    k_s1;
	logic [WEIGHT_W-1:0] w_q;
	logic [CAND_W-1:0]   best_q;
	logic [IDX_W-1:0]    best_k_q;
	logic                out_vld_q;

	logic                accept;
	logic [IDX_W-1:0]    n_eff;
	logic [CAND_W-1:0]   cand;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   w_rd_addr;
	logic [ADDR_W-1:0]   ca_addr;
	logic [ADDR_W-1:0]   cb_addr;
	logic [IDX_W-1:0]    store_sel;
	logic [CAND_W-1:0]   cost_sum;

	assign accept = in_valid && !in_stall;

	// effective key count: zero acts as one, clamp at the maximum
	always_comb begin
		if (key_count_q == '0) begin
			n_eff = IDX_W'(1);
		end else if (key_count_q > IDX_W'(MAX_KEYS)) begin
			n_eff = IDX_W'(MAX_KEYS);
		end else begin
			n_eff = key_count_q;
		end
	end

	assign sts.n        = n_eff;
	assign sts.start    = accept && (weight_index == n_eff);
	assign sts.out_free = !out_vld_q || !out_stall;

	// key count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= IDX_W'(5);
		end else if (cfg_wr_en) begin
			key_count_q <= cfg_wr_data;
		end
	end

	// weight stores, loaded one index per request
	always_ff @(posedge clk) begin
		if (accept && (weight_index <= IDX_W'(MAX_KEYS))) begin
			succ_q[weight_index[KEY_W-1:0]] <= success_weight;
			fail_q[weight_index[KEY_W-1:0]] <= failure_weight;
		end
	end

	// table addresses
	assign store_sel = cmd.diag_wr ? cmd.i : cmd.j;
	assign wr_addr   = cmd.diag_wr ? span_addr(cmd.i, cmd.i) : span_addr(cmd.i, cmd.j);
	assign w_rd_addr = cmd.wsum ? span_addr(cmd.i, cmd.j - IDX_W'(1))
	                            : span_addr(cmd.i, cmd.j);
	assign ca_addr   = cmd.scan ? span_addr(cmd.i, cmd.k - IDX_W'(1))
	                            : span_addr(cmd.i, cmd.j);
	assign cb_addr   = span_addr(cmd.k, cmd.j);
	assign cost_sum  = CAND_W'(w_q) + best_q;

	// span tables: one write port, registered reads
	always_ff @(posedge clk) begin
		if (cmd.diag_wr) begin
			wmem[wr_addr] <= WEIGHT_W'(fail_q[store_sel[KEY_W-1:0]]);
			cmem[wr_addr] <= '0;
			rmem[wr_addr] <= '0;
		end else if (cmd.span_wr) begin
			wmem[wr_addr] <= w_q;
			cmem[wr_addr] <= cost_sum[COST_W-1:0];
			rmem[wr_addr] <= best_k_q;
		end
		if (cmd.wsum || cmd.out_rd) begin
			wt_rd_q <= wmem[w_rd_addr];
		end
		if (cmd.scan || cmd.out_rd) begin
			ca_q <= cmem[ca_addr];
		end
		if (cmd.scan) begin
			cb_q <= cmem[cb_addr];
		end
		if (cmd.out_rd) begin
			rt_rd_q <= rmem[span_addr(cmd.i, cmd.j)];
		end
	end

	// control flags of the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_s1 <= 1'b0;
			scan_s1 <= 1'b0;
		end else begin
			wsum_s1 <= cmd.wsum;
			scan_s1 <= cmd.scan;
		end
	end

	// payload of the read stage
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		k_s1     <= cmd.k;
		if (cmd.wsum) begin
			pq_s1 <= WEIGHT_W'(succ_q[store_sel[KEY_W-1:0]])
			       + WEIGHT_W'(fail_q[store_sel[KEY_W-1:0]]);
		end
	end

	assign cand = CAND_W'(ca_q) + CAND_W'(cb_q);

	// span weight and running minimum over root candidates, first minimum kept
	always_ff @(posedge clk) begin
		if (wsum_s1) begin
			w_q <= wt_rd_q + pq_s1;
		end
		if (scan_s1 && (first_s1 || (cand < best_q))) begin
			best_q   <= cand;
			best_k_q <= k_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			span_start  <= cmd.i;
			span_end    <= cmd.j;
			span_weight <= wt_rd_q;
			span_cost   <= ca_q;
			span_root   <= rt_rd_q;
			final_entry <= cmd.out_last;
		end
	end

	assign out_valid = out_vld_q;

endmodule

`default_nettype wire

/* hw/rtl/obst_ctrl.sv */
// controller: sequences table init, span solving and table readout
`timescale 1ns / 1ps
`default_nettype none

module obst_ctrl
	import obst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire obst_sts_t sts,
	output obst_cmd_t      cmd,
	output logic           in_stall
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIAG,
		ST_SPAN,
		ST_SCAN,
		ST_FIN,
		ST_WR,
		ST_OUT_RD,
		ST_OUT_WAIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] j;

	assign j        = i_q + len_q;
	assign in_stall = (state_q != ST_IDLE);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.i        = i_q;
		cmd.j        = j;
		cmd.k        = (state_q == ST_SPAN) ? i_q + IDX_W'(1) : k_q;
		cmd.out_last = (len_q == sts.n);
		case (state_q)
			ST_DIAG: begin
				cmd.diag_wr = 1'b1;
			end
			ST_SPAN: begin
				cmd.wsum  = 1'b1;
				cmd.scan  = 1'b1;
				cmd.first = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_WR: begin
				cmd.span_wr = 1'b1;
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
			end
			ST_OUT_WAIT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			len_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sts.start) begin
						i_q     <= '0;
						len_q   <= '0;
						state_q <= ST_DIAG;
					end
				end
				// empty spans
				ST_DIAG: begin
					if (i_q == sts.n) begin
						i_q     <= '0;
						len_q   <= IDX_W'(1);
						state_q <= ST_SPAN;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				// first root candidate issued with the weight read
				ST_SPAN: begin
					k_q     <= i_q + IDX_W'(2);
					state_q <= (len_q == IDX_W'(1)) ? ST_FIN : ST_SCAN;
				end
				ST_SCAN: begin
					if (k_q == j) begin
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				// last compare lands
				ST_FIN: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (j == sts.n) begin
						i_q <= '0;
						if (len_q == sts.n) begin
							len_q   <= '0;
							state_q <= ST_OUT_RD;
						end else begin
							len_q   <= len_q + IDX_W'(1);
							state_q <= ST_SPAN;
						end
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= ST_SPAN;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_WAIT;
				end
				// wait for room in the output register
				ST_OUT_WAIT: begin
					if (sts.out_free) begin
						if (j == sts.n) begin
							i_q <= '0;
							if (len_q == sts.n) begin
								state_q <= ST_IDLE;
							end else begin
								len_q   <= len_q + IDX_W'(1);
								state_q <= ST_OUT_RD;
							end
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/optimal_bst_table_builder.sv */
// top level of the optimal binary search tree table builder
`timescale 1ns / 1ps
`default_nettype none

// Each request loads the success and failure weight of one index; indices above
// MAX_KEYS are dropped. The request whose index equals the key count n (0 acts as
// 1, values above MAX_KEYS clamp) starts a run, and the block stalls requests until
// the run has handed its last entry to the output register. A run writes the n+1
// empty spans, then solves each span with one root candidate compared per cycle
// through the two read ports of the cost table, then reads out all (n+1)(n+2)/2
// spans by increasing length, waiting for room in the output register. Entries
// carry start, end, weight, cost and root; the span (0, n) is flagged last.
module optimal_bst_table_builder
	import obst_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [IDX_W-1:0]    cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [IDX_W-1:0]    weight_index,
	input  wire logic [WIN_W-1:0]    success_weight,
	input  wire logic [WIN_W-1:0]    failure_weight,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [IDX_W-1:0]         span_start,
	output logic [IDX_W-1:0]         span_end,
	output logic [WEIGHT_W-1:0]      span_weight,
	output logic [COST_W-1:0]        span_cost,
	output logic [IDX_W-1:0]         span_root,
	output logic                     final_entry
);

	obst_cmd_t cmd;
	obst_sts_t sts;

	obst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	obst_dpath #(
		.MAX_KEYS (MAX_KEYS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.weight_index   (weight_index),
		.success_weight (success_weight),
		.failure_weight (failure_weight),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.span_start     (span_start),
		.span_end       (span_end),
		.span_weight    (span_weight),
		.span_cost      (span_cost),
		.span_root      (span_root),
		.final_entry    (final_entry)
	);

endmodule

`default_nettype wire

/* verif/tb_optimal_bst_table_builder.sv */
// self-checking testbench for the optimal binary search tree table builder
`timescale 1ns / 1ps

module tb_optimal_bst_table_builder;
	import obst_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int TARGET_REQS = 460;

	// one weight load request
	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [WIN_W-1:0] sw;
		logic [WIN_W-1:0] fw;
	} weight_req_t;

	// one reported table entry
	typedef struct {
		logic [IDX_W-1:0]    s_from;
		logic [IDX_W-1:0]    s_to;
		logic [WEIGHT_W-1:0] weight;
		logic [COST_W-1:0]   cost;
		logic [IDX_W-1:0]    root;
		logic                last;
	} span_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [IDX_W-1:0]    weight_index = '0;
	logic [WIN_W-1:0]    success_weight = '0;
	logic [WIN_W-1:0]    failure_weight = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [IDX_W-1:0]    span_start;
	logic [IDX_W-1:0]    span_end;
	logic [WEIGHT_W-1:0] span_weight;
	logic [COST_W-1:0]   span_cost;
	logic [IDX_W-1:0]    span_root;
	logic                final_entry;

	// predictor state: loaded weights and the current key count
	logic [WIN_W-1:0] known_p [0:MAX_KEYS_DEF];
	logic [WIN_W-1:0] known_q [0:MAX_KEYS_DEF];
	logic [IDX_W-1:0] tree_keys = 4'd5;

	weight_req_t weight_reqs[$];
	weight_req_t cur_req;
	span_t       awaited_spans[$];
	span_t       want;
	int          idle_pct = 26;
	int          fails = 0;
	int          fed = 0;
	int          quiet_cycles = 0;

	optimal_bst_table_builder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.weight_index   (weight_index),
		.success_weight (success_weight),
		.failure_weight (failure_weight),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.span_start     (span_start),
		.span_end       (span_end),
		.span_weight    (span_weight),
		.span_cost      (span_cost),
		.span_root      (span_root),
		.final_entry    (final_entry)
	);

	always #10 clk = ~clk;

	// store the weights and, when the key count index arrives, solve every span
	task automatic solve_tree_tables(input weight_req_t req);
		int n, len, i, j, k, cand, best;
		int w_t [0:MAX_KEYS_DEF][0:MAX_KEYS_DEF];
		int c_t [0:MAX_KEYS_DEF][0:MAX_KEYS_DEF];
		int r_t [0:MAX_KEYS_DEF][0:MAX_KEYS_DEF];
		span_t s;
		if (req.idx <= MAX_KEYS_DEF) begin
			known_p[req.idx] = req.sw;
			known_q[req.idx] = req.fw;
			// zero acts as one, large counts clamp
			n = (tree_keys == 0) ? 1 :
				((tree_keys > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(tree_keys));
			if (req.idx == n) begin
				for (i = 0; i <= n; i++) begin
					w_t[i][i] = int'(known_q[i]);
					c_t[i][i] = 0;
					r_t[i][i] = 0;
				end
				// lowest candidate root wins a tie
				for (len = 1; len <= n; len++) begin
					for (i = 0; i + len <= n; i++) begin
						j = i + len;
						w_t[i][j] = w_t[i][j-1] + int'(known_p[j]) + int'(known_q[j]);
						best = -1;
						for (k = i + 1; k <= j; k++) begin
							cand = c_t[i][k-1] + c_t[k][j];
							if (best < 0 || cand < best) begin
								best = cand;
								r_t[i][j] = k;
							end
						end
						c_t[i][j] = w_t[i][j] + best;
					end
				end
				// entries leave by increasing span length, then start index
				for (len = 0; len <= n; len++) begin
					for (i = 0; i + len <= n; i++) begin
						j = i + len;
						s.s_from = IDX_W'(i);
						s.s_to   = IDX_W'(j);
						s.weight = WEIGHT_W'(w_t[i][j]);
						s.cost   = COST_W'(c_t[i][j]);
						s.root   = IDX_W'(r_t[i][j]);
						s.last   = (len == n);
						awaited_spans.push_back(s);
					end
				end
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				solve_tree_tables(cur_req);
			end
			if (!in_valid || !in_stall) begin
				if (weight_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_req = weight_reqs.pop_front();
					in_valid       <= 1'b1;
					weight_index   <= cur_req.idx;
					success_weight <= cur_req.sw;
					failure_weight <= cur_req.fw;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_spans.size() == 0) begin
					$error("unexpected entry for span %0d..%0d", span_start, span_end);
					fails++;
				end else begin
					want = awaited_spans.pop_front();
					if (span_start !== want.s_from) begin
						$error("span_start expected %0d got %0d", want.s_from, span_start);
						fails++;
					end
					if (span_end !== want.s_to) begin
						$error("span_end expected %0d got %0d", want.s_to, span_end);
						fails++;
					end
					if (span_weight !== want.weight) begin
						$error("span_weight expected %0d got %0d", want.weight, span_weight);
						fails++;
					end
					if (span_cost !== want.cost) begin
						$error("span_cost expected %0d got %0d", want.cost, span_cost);
						fails++;
					end
					if (span_root !== want.root) begin
						$error("span_root expected %0d got %0d", want.root, span_root);
						fails++;
					end
					if (final_entry !== want.last) begin
						$error("final_entry expected %0d got %0d", want.last, final_entry);
						fails++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [WIN_W-1:0] pick_weight();
		int roll;
		roll = $urandom_range(99);
		if (roll < 12) begin
			return '0;
		end else if (roll < 24) begin
			return '1;
		end else if (roll < 44) begin
			// small weights make cost ties common
			return WIN_W'($urandom_range(3));
		end else begin
			return WIN_W'($urandom_range(255));
		end
	endfunction

	task automatic push_req(input int idx, input int sw, input int fw);
		weight_req_t req;
		req.idx = IDX_W'(idx);
		req.sw  = WIN_W'(sw);
		req.fw  = WIN_W'(fw);
		weight_reqs.push_back(req);
		fed++;
	endtask

	// well-formed load of indices 0..top
	task automatic add_sequence(input int top);
		int k;
		for (k = 0; k <= top; k++) begin
			push_req(k, pick_weight(), pick_weight());
		end
	endtask

	// wait until every request is in and every entry is out, sampled mid-cycle
	task automatic drain();
		do begin
			@(negedge clk);
		end while (weight_reqs.size() != 0 || in_valid || awaited_spans.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_key_count(input int value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= IDX_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tree_keys = IDX_W'(value);
	endtask

	// stimulus
	initial begin
		int phase, n_eff, phase_reqs, roll, keys;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored index, field extremes, run at the reset key count
		push_req(15, 8'hAA, 8'h55);
		push_req(0, 255, 0);
		push_req(1, 255, 255);
		push_req(2, 0, 255);
		push_req(3, 1, 2);
		push_req(4, 128, 127);
		push_req(5, 3, 4);
		push_req(6, 7, 8);
		push_req(7, 255, 0);
		push_req(8, 0, 0);
		// zero key count acts as one, with a load below it first
		set_key_count(0);
		push_req(0, 9, 17);
		push_req(1, 33, 65);
		// all-zero weights: every root candidate ties
		set_key_count(3);
		add_sequence(-1);
		push_req(0, 0, 0);
		push_req(1, 0, 0);
		push_req(2, 0, 0);
		push_req(3, 0, 0);
		// oversized key count clamps to the maximum
		set_key_count(15);
		push_req(3, 200, 100);
		push_req(8, 255, 255);
		// largest weights everywhere
		set_key_count(8);
		push_req(0, 255, 255);
		push_req(1, 255, 255);
		push_req(2, 255, 255);
		push_req(3, 255, 255);
		push_req(4, 255, 255);
		push_req(5, 255, 255);
		push_req(6, 255, 255);
		push_req(7, 255, 255);
		push_req(8, 255, 255);

		// random phases, one key count each
		phase = 0;
		while (fed < TARGET_REQS) begin
			case (phase % 6)
				0: keys = 8;
				1: keys = 1;
				2: keys = 0;
				3: keys = 15;
				default: keys = $urandom_range(7, 2);
			endcase
			set_key_count(keys);
			n_eff = (keys == 0) ? 1 : ((keys > MAX_KEYS_DEF) ? MAX_KEYS_DEF : keys);
			// one phase runs without any idling on either side
			idle_pct = (phase == 3) ? 0 : 26;
			phase_reqs = fed;
			while (fed - phase_reqs < 30) begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					add_sequence(n_eff);
				end else if (roll < 80) begin
					add_sequence($urandom_range(n_eff - 1, 0));
				end else if (roll < 90) begin
					push_req($urandom_range(MAX_KEYS_DEF), pick_weight(), pick_weight());
				end else begin
					push_req($urandom_range(15, MAX_KEYS_DEF + 1), pick_weight(), pick_weight());
				end
			end
			phase++;
		end

		drain();
		if (fails == 0 && awaited_spans.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
